// File: rtl/itr_pkg.sv
package itr_pkg;

	localparam int unsigned FrameLenW  = 4;
	localparam int unsigned FrameDataW = 64;
	localparam int unsigned PayloadW   = 56;
	localparam int unsigned MsgLenW    = 12;
	localparam int unsigned CfgIndexW  = 2;
	localparam int unsigned CfgDataW   = 12;

	// PCI frame types (top nibble of byte 0)
	localparam logic [3:0] PCI_SINGLE      = 4'h0;
	localparam logic [3:0] PCI_FIRST       = 4'h1;
	localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

	typedef enum logic [CfgIndexW-1:0] {
		REG_BLOCK_SIZE         = 2'd0,
		REG_SEPARATION_TIME    = 2'd1,
		REG_MAX_MESSAGE_LENGTH = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		KIND_IGNORED          = 3'd0,
		KIND_SINGLE_DONE      = 3'd1,
		KIND_FIRST_OK         = 3'd2,
		KIND_CONSECUTIVE      = 3'd3,
		KIND_LAST_CONSECUTIVE = 3'd4,
		KIND_OVERFLOW         = 3'd5,
		KIND_SEQUENCE_ERROR   = 3'd6
	} result_kind_t;

	typedef enum logic [1:0] {
		FC_NONE     = 2'd0,
		FC_CONTINUE = 2'd1,
		FC_OVERFLOW = 2'd2
	} flow_control_t;

	typedef struct packed {
		logic [FrameLenW-1:0]  frame_length;
		logic [FrameDataW-1:0] frame_data;
	} frame_t;

	typedef struct packed {
		result_kind_t          kind;
		logic [PayloadW-1:0]   payload_data;
		logic [2:0]            payload_count;
		logic [MsgLenW-1:0]    payload_offset;
		logic [MsgLenW-1:0]    message_length;
		flow_control_t         send_flow_control;
		logic                  start_of_reception;
		logic                  message_complete;
	} result_t;

endpackage

// File: rtl/iso_tp_receiver_unit.sv
// A frame transfer reaches its offered result through the input register, then
//   decode into the result register.
// Throughput: one frame per cycle while results are taken; the decode and the
//   reception state update both sit in the single stage between the two registers.
// Reset: arst_n clears the pipeline valids and the reception state (idle,
//   expected sequence 1) and loads block_size 0, max_message_length 4095.
module iso_tp_receiver_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            frame_valid,
	output logic                            frame_ready,
	input  itr_pkg::frame_t                 frame,
	output logic                            result_valid,
	input  logic                            result_ready,
	output itr_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [itr_pkg::CfgIndexW-1:0]   cfg_index,
	input  logic [itr_pkg::CfgDataW-1:0]    cfg_data
);
	import itr_pkg::*;

	// Keep the top count bytes of a 7-byte payload, zero the rest.
	function automatic logic [PayloadW-1:0] byte_mask(input logic [2:0] count);
		logic [PayloadW-1:0] m;
		m = '0;
		for (int i = 0; i < 7; i++) begin
			if (3'(i) < count) begin
				m[PayloadW-1-8*i -: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	// Configuration registers. STmin only goes into the transmitted flow
	// control frame, which is assembled outside this block, so it is not held.
	logic [7:0]         block_size_q;
	logic [MsgLenW-1:0] max_message_length_q;

	// Reception state
	logic               in_segmented_q;
	logic [3:0]         expected_sequence_q;
	logic [MsgLenW-1:0] bytes_received_q;
	logic [MsgLenW-1:0] total_length_q;
	logic [7:0]         frames_in_block_q;

	// Pipeline registers
	logic    valid_s1;
	frame_t  frame_s1;
	logic    valid_s2;
	result_t result_s2;

	logic advance_s2;
	logic step_s1;

	// Decode outputs and next state
	result_t            res_d;
	logic               in_segmented_d;
	logic [3:0]         expected_sequence_d;
	logic [MsgLenW-1:0] bytes_received_d;
	logic [MsgLenW-1:0] total_length_d;
	logic [7:0]         frames_in_block_d;

	// The result register frees up when empty or when its result is taken;
	// the input register moves on whenever the result register does.
	assign advance_s2   = !valid_s2 || result_ready;
	assign step_s1      = valid_s1 && advance_s2;
	assign frame_ready  = !valid_s1 || advance_s2;
	assign result_valid = valid_s2;
	assign result       = result_s2;
	assign cfg_ready    = 1'b1;

	// Configuration writes; an index past the register list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q         <= '0;
			max_message_length_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BLOCK_SIZE:         block_size_q         <= cfg_data[7:0];
				REG_SEPARATION_TIME:    ; // consumed by the flow control sender
				REG_MAX_MESSAGE_LENGTH: max_message_length_q <= cfg_data;
				default:                ;
			endcase
		end
	end

	// Frame decode: classify by PCI type, check, and work out the next state.
	always_comb begin
		logic [3:0]         flen;
		logic [3:0]         flen_m1;
		logic [3:0]         pci_type;
		logic [3:0]         pci_low;
		logic [MsgLenW-1:0] announced;
		logic [MsgLenW-1:0] remain;
		logic [2:0]         copy;
		logic [MsgLenW-1:0] received_next;
		logic [7:0]         block_count;

		flen          = (frame_s1.frame_length > 4'd8) ? 4'd8 : frame_s1.frame_length;
		flen_m1       = flen - 4'd1;
		pci_type      = frame_s1.frame_data[63:60];
		pci_low       = frame_s1.frame_data[59:56];
		announced     = {pci_low, frame_s1.frame_data[55:48]};
		remain        = total_length_q - bytes_received_q;
		copy          = ({8'd0, flen_m1} > remain) ? remain[2:0] : flen_m1[2:0];
		received_next = bytes_received_q + {9'd0, copy};
		block_count   = frames_in_block_q + 8'd1;

		res_d               = '0;
		res_d.kind          = KIND_IGNORED;
		res_d.send_flow_control = FC_NONE;
		in_segmented_d      = in_segmented_q;
		expected_sequence_d = expected_sequence_q;
		bytes_received_d    = bytes_received_q;
		total_length_d      = total_length_q;
		frames_in_block_d   = frames_in_block_q;

		if (flen != 4'd0) begin
			case (pci_type)
				PCI_SINGLE: begin
					if (pci_low != 4'd0 && pci_low <= flen_m1) begin
						in_segmented_d           = 1'b0;
						res_d.kind               = KIND_SINGLE_DONE;
						res_d.payload_count      = pci_low[2:0];
						res_d.payload_data       = frame_s1.frame_data[55:0] &
							byte_mask(pci_low[2:0]);
						res_d.message_length     = {8'd0, pci_low};
						res_d.start_of_reception = 1'b1;
						res_d.message_complete   = 1'b1;
					end
				end
				PCI_FIRST: begin
					// Need a full frame and a message too long for a single frame.
					if (flen == 4'd8 && announced >= MsgLenW'(8)) begin
						in_segmented_d       = 1'b0;
						res_d.message_length = announced;
						if (announced > max_message_length_q) begin
							res_d.kind              = KIND_OVERFLOW;
							res_d.send_flow_control = FC_OVERFLOW;
						end else begin
							res_d.kind               = KIND_FIRST_OK;
							res_d.payload_count      = 3'd6;
							res_d.payload_data       = {frame_s1.frame_data[47:0], 8'h00};
							res_d.send_flow_control  = FC_CONTINUE;
							res_d.start_of_reception = 1'b1;
							in_segmented_d           = 1'b1;
							expected_sequence_d      = 4'd1;
							bytes_received_d         = MsgLenW'(6);
							total_length_d           = announced;
							frames_in_block_d        = '0;
						end
					end
				end
				PCI_CONSECUTIVE: begin
					if (in_segmented_q) begin
						res_d.message_length = total_length_q;
						res_d.payload_offset = bytes_received_q;
						if (pci_low != expected_sequence_q) begin
							// Abandon the reception.
							res_d.kind     = KIND_SEQUENCE_ERROR;
							in_segmented_d = 1'b0;
						end else begin
							res_d.payload_count = copy;
							res_d.payload_data  = frame_s1.frame_data[55:0] & byte_mask(copy);
							bytes_received_d    = received_next;
							expected_sequence_d = expected_sequence_q + 4'd1;
							if (received_next >= total_length_q) begin
								res_d.kind             = KIND_LAST_CONSECUTIVE;
								res_d.message_complete = 1'b1;
								in_segmented_d         = 1'b0;
							end else begin
								res_d.kind        = KIND_CONSECUTIVE;
								frames_in_block_d = block_count;
								if (block_size_q != 8'd0 && block_count >= block_size_q) begin
									res_d.send_flow_control = FC_CONTINUE;
									frames_in_block_d       = '0;
								end
							end
						end
					end
				end
				default: ; // flow control and unknown types are dropped
			endcase
		end
	end

	// Pipeline valids and reception state; state advances as an item leaves s1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1            <= 1'b0;
			valid_s2            <= 1'b0;
			in_segmented_q      <= 1'b0;
			expected_sequence_q <= 4'd1;
			bytes_received_q    <= '0;
			total_length_q      <= '0;
			frames_in_block_q   <= '0;
		end else begin
			if (frame_valid && frame_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance_s2) begin
				valid_s1 <= 1'b0;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
			if (step_s1) begin
				in_segmented_q      <= in_segmented_d;
				expected_sequence_q <= expected_sequence_d;
				bytes_received_q    <= bytes_received_d;
				total_length_q      <= total_length_d;
				frames_in_block_q   <= frames_in_block_d;
			end
		end
	end

	// Payload registers: capture on transfer, hold while stalled.
	always_ff @(posedge clk) begin
		if (frame_valid && frame_ready) begin
			frame_s1 <= frame;
		end
		if (step_s1) begin
			result_s2 <= res_d;
		end
	end

endmodule

// File: test/tb_iso_tp_receiver_unit.sv
module tb_iso_tp_receiver_unit;
	import itr_pkg::*;

	// Stop the run here if the transfers stall for good.
	localparam int unsigned CycleLimit  = 200000;
	// Results pass the input and result registers; leave some slack on top.
	localparam int unsigned DrainCycles = 4;
	// PCI types the block never accepts.
	localparam logic [3:0] PciFlowControl = 4'h3;
	localparam logic [3:0] PciReserved    = 4'hf;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 frame_valid  = 1'b0;
	logic                 frame_ready;
	frame_t               frame        = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index    = '0;
	logic [CfgDataW-1:0]  cfg_data     = '0;

	// Register copies, updated when a register write transfer completes.
	logic [7:0]  block_size_reg  = 8'd0;
	logic [7:0]  stmin_reg       = 8'd0;
	logic [11:0] max_len_reg     = 12'hfff;

	// Reception state of the receiver as the checker sees it.
	logic        rx_active = 1'b0;
	logic [3:0]  rx_seq    = 4'd1;
	logic [11:0] rx_count  = '0;
	logic [11:0] rx_total  = '0;
	logic [7:0]  rx_blk    = '0;

	frame_t      pending_frames[$];
	result_t     expected_results[$];
	int unsigned queued_count   = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	logic        hold_sender    = 1'b0;

	// Sender burst/gap and receiver stall bookkeeping.
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;

	iso_tp_receiver_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Pull n frame bytes starting at byte 'first' up to the top of the payload field;
	// the unused low bytes stay zero.
	function automatic logic [PayloadW-1:0] take_bytes(logic [63:0] data, int unsigned first,
			int unsigned n);
		logic [63:0]         shifted;
		logic [PayloadW-1:0] keep;
		shifted = data << (8 * first);
		keep    = ~({PayloadW{1'b1}} >> (8 * n));
		return shifted[63:8] & keep;
	endfunction

	// Classify one frame, update the reception state and return the result it must cause.
	function automatic result_t decode_frame(frame_t f);
		result_t     r;
		logic [3:0]  flen;
		logic [3:0]  pci_type;
		logic [3:0]  pci_low;
		logic [11:0] announced;
		logic [11:0] room;
		logic [11:0] take;
		r         = '0;
		// Lengths above 8 behave as a full frame.
		flen      = (f.frame_length > 4'd8) ? 4'd8 : f.frame_length;
		pci_type  = f.frame_data[63:60];
		pci_low   = f.frame_data[59:56];
		announced = {pci_low, f.frame_data[55:48]};
		if (flen == 4'd0)
			return r;
		if (pci_type == PCI_SINGLE) begin
			// Length nibble must fit in the frame behind the PCI byte.
			if (pci_low != 4'd0 && pci_low <= flen - 4'd1) begin
				rx_active            = 1'b0;
				r.kind               = KIND_SINGLE_DONE;
				r.payload_data       = take_bytes(f.frame_data, 1, pci_low);
				r.payload_count      = pci_low[2:0];
				r.message_length     = 12'(pci_low);
				r.start_of_reception = 1'b1;
				r.message_complete   = 1'b1;
			end
		end else if (pci_type == PCI_FIRST) begin
			// Short first frames and messages that would fit a single frame are dropped.
			if (flen == 4'd8 && announced >= 12'd8) begin
				rx_active        = 1'b0;
				r.message_length = announced;
				if (announced > max_len_reg) begin
					r.kind              = KIND_OVERFLOW;
					r.send_flow_control = FC_OVERFLOW;
				end else begin
					r.kind               = KIND_FIRST_OK;
					r.payload_data       = take_bytes(f.frame_data, 2, 6);
					r.payload_count      = 3'd6;
					r.send_flow_control  = FC_CONTINUE;
					r.start_of_reception = 1'b1;
					rx_active            = 1'b1;
					rx_seq               = 4'd1;
					rx_count             = 12'd6;
					rx_total             = announced;
					rx_blk               = 8'd0;
				end
			end
		end else if (pci_type == PCI_CONSECUTIVE && rx_active) begin
			r.message_length = rx_total;
			r.payload_offset = rx_count;
			if (pci_low != rx_seq) begin
				r.kind    = KIND_SEQUENCE_ERROR;
				rx_active = 1'b0;
			end else begin
				// Copy what the frame holds, capped at what the message still lacks.
				room = rx_total - rx_count;
				take = 12'(flen - 4'd1);
				if (take > room)
					take = room;
				r.payload_data  = take_bytes(f.frame_data, 1, take);
				r.payload_count = take[2:0];
				rx_count        = rx_count + take;
				rx_seq          = rx_seq + 4'd1;
				if (rx_count >= rx_total) begin
					r.kind             = KIND_LAST_CONSECUTIVE;
					r.message_complete = 1'b1;
					rx_active          = 1'b0;
				end else begin
					r.kind = KIND_CONSECUTIVE;
					rx_blk = rx_blk + 8'd1;
					if (block_size_reg != 8'd0 && rx_blk >= block_size_reg) begin
						r.send_flow_control = FC_CONTINUE;
						rx_blk              = 8'd0;
					end
				end
			end
		end
		return r;
	endfunction

	task automatic queue_frame(logic [3:0] len, logic [63:0] data);
		frame_t f;
		f.frame_length = len;
		f.frame_data   = data;
		pending_frames.push_back(f);
		queued_count++;
	endtask

	// Queue a first frame and its consecutive frames with random content. With
	// allow_break set, the message may end early on a bad sequence number, a
	// single frame, or nothing at all.
	task automatic queue_message(int unsigned total, bit allow_break);
		int unsigned sent;
		logic [3:0]  seq;
		logic [3:0]  len;
		sent = 6;
		seq  = 4'd1;
		queue_frame(($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15)) : 4'd8,
			{PCI_FIRST, 12'(total), 48'(random_word())});
		while (sent < total) begin
			if (allow_break && $urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 2))
					0: queue_frame(4'd8,
						{PCI_CONSECUTIVE, seq + 4'($urandom_range(1, 15)), 56'(random_word())});
					1: queue_frame(4'd8, {PCI_SINGLE, 4'd7, 56'(random_word())});
					default: ;
				endcase
				return;
			end
			// Mostly full frames; some empty, short or oversized ones.
			case ($urandom_range(0, 11))
				0:       len = 4'd0;
				1, 2:    len = 4'($urandom_range(1, 7));
				3:       len = 4'($urandom_range(9, 15));
				default: len = 4'd8;
			endcase
			queue_frame(len, {PCI_CONSECUTIVE, seq, 56'(random_word())});
			if (len != 4'd0) begin
				sent += int'((len > 4'd8) ? 4'd8 : len) - 1;
				seq++;
			end
		end
	endtask

	// Mix of well-formed messages, single frames, bare first frames and noise.
	task automatic queue_random(int unsigned count);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned total;
		logic [3:0]  low;
		stop_at = queued_count + count;
		while (queued_count < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					total = $urandom_range(8, 40);
				else if (pick < 9)
					total = $urandom_range(41, 200);
				else
					total = $urandom_range(201, 600);
				// Keep the message acceptable unless nothing fits at all.
				if (max_len_reg >= 12'd8 && total > max_len_reg)
					total = $urandom_range(8, max_len_reg);
				queue_message(total, 1'b1);
			end else if (pick < 75) begin
				low = 4'($urandom_range(1, 7));
				queue_frame(4'($urandom_range(low + 1, 15)), {PCI_SINGLE, low, 56'(random_word())});
			end else if (pick < 85) begin
				queue_frame(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8,
					{PCI_FIRST, 60'(random_word())});
			end else begin
				queue_frame(4'($urandom_range(0, 15)), random_word());
			end
		end
	endtask

	task automatic write_register(cfg_reg_t index, logic [CfgDataW-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (index)
			REG_BLOCK_SIZE:         block_size_reg = value[7:0];
			REG_SEPARATION_TIME:    stmin_reg      = value[7:0];
			REG_MAX_MESSAGE_LENGTH: max_len_reg    = value;
			default: ;
		endcase
	endtask

	// Hold until no frame is offered and every expected result has arrived.
	task automatic wait_results();
		@(posedge clk);
		while (frame_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic drain_all();
		while (pending_frames.size() != 0)
			@(posedge clk);
		wait_results();
	endtask

	// Frame driver: offer queued frames in bursts, predict each frame at its transfer.
	always @(posedge clk or negedge arst_n) begin : drive_frames
		logic valid_next;
		if (!arst_n) begin
			frame_valid <= 1'b0;
			frame       <= '0;
		end else begin
			valid_next = frame_valid;
			if (frame_valid && frame_ready) begin
				expected_results.push_back(decode_frame(frame));
				valid_next = 1'b0;
			end
			// Valid stays up until the transfer; only a free slot takes the next frame.
			if (!valid_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_frames.size() > 0 && !hold_sender) begin
					frame      <= pending_frames.pop_front();
					valid_next = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
							: $urandom_range(0, 4);
					end
				end
			end
			frame_valid <= valid_next;
		end
	end

	// Result monitor: compare each transfer with the oldest prediction, then pick the
	// next ready value from the current stall pattern.
	always @(posedge clk or negedge arst_n) begin : check_results
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d", result.kind);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result.kind);
						mismatch_count++;
					end
					if (result.payload_data !== want.payload_data) begin
						$error("payload_data: expected %h, got %h", want.payload_data,
							result.payload_data);
						mismatch_count++;
					end
					if (result.payload_count !== want.payload_count) begin
						$error("payload_count: expected %0d, got %0d", want.payload_count,
							result.payload_count);
						mismatch_count++;
					end
					if (result.payload_offset !== want.payload_offset) begin
						$error("payload_offset: expected %0d, got %0d", want.payload_offset,
							result.payload_offset);
						mismatch_count++;
					end
					if (result.message_length !== want.message_length) begin
						$error("message_length: expected %0d, got %0d", want.message_length,
							result.message_length);
						mismatch_count++;
					end
					if (result.send_flow_control !== want.send_flow_control) begin
						$error("send_flow_control: expected %0d, got %0d",
							want.send_flow_control, result.send_flow_control);
						mismatch_count++;
					end
					if (result.start_of_reception !== want.start_of_reception) begin
						$error("start_of_reception: expected %0d, got %0d",
							want.start_of_reception, result.start_of_reception);
						mismatch_count++;
					end
					if (result.message_complete !== want.message_complete) begin
						$error("message_complete: expected %0d, got %0d",
							want.message_complete, result.message_complete);
						mismatch_count++;
					end
				end
			end
			// Switch between always ready, coin flips and a one-in-four stall.
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(16, 128);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0:       result_ready <= 1'b1;
				1:       result_ready <= 1'($urandom_range(0, 1));
				default: result_ready <= ((cycle_count % 4) != 3);
			endcase
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : run_test
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset register values: every corner of frame decoding.
		queue_frame(4'd0, {PCI_SINGLE, 4'd3, 56'(random_word())});          // empty frame
		queue_frame(4'd15, {PCI_SINGLE, 4'd7, 56'hff_ffff_ffff_ffff});      // oversized length
		queue_frame(4'd8, {PCI_SINGLE, 4'd0, 56'(random_word())});          // zero length nibble
		queue_frame(4'd3, {PCI_SINGLE, 4'd3, 56'(random_word())});          // nibble past frame end
		queue_frame(4'd2, {PCI_SINGLE, 4'd1, 56'h0});                       // one-byte single
		queue_frame(4'd7, {PCI_FIRST, 12'd20, 48'(random_word())});         // short first frame
		queue_frame(4'd8, {PCI_FIRST, 12'd7, 48'(random_word())});          // announces under 8
		queue_frame(4'd8, {PCI_FIRST, 12'hfff, 48'hffff_ffff_ffff});        // largest message
		queue_frame(4'd8, {PCI_CONSECUTIVE, 4'd2, 56'(random_word())});     // wrong sequence
		queue_frame(4'd8, {PCI_CONSECUTIVE, 4'd1, 56'(random_word())});     // stray while idle
		queue_frame(4'd8, {PCI_FIRST, 12'd8, 48'(random_word())});
		queue_frame(4'd1, {PCI_CONSECUTIVE, 4'd1, 56'(random_word())});     // copies no bytes
		queue_frame(4'd8, {PCI_CONSECUTIVE, 4'd2, 56'(random_word())});     // last, two bytes
		queue_frame(4'd8, {PCI_FIRST, 12'd30, 48'(random_word())});
		queue_frame(4'd8, {PCI_SINGLE, 4'd4, 56'(random_word())});          // single cuts message
		queue_frame(4'd8, {PCI_CONSECUTIVE, 4'd1, 56'(random_word())});     // now stray
		queue_frame(4'd3, {PciFlowControl, 4'd0, 56'(random_word())});      // flow control frame
		queue_frame(4'd8, {PciReserved, 60'(random_word())});               // unknown PCI type
		queue_frame(4'd8, {PCI_FIRST, 12'd20, 48'(random_word())});
		queue_frame(4'd8, {PCI_FIRST, 12'd9, 48'(random_word())});          // first cuts message
		queue_frame(4'd12, {PCI_CONSECUTIVE, 4'd1, 56'(random_word())});    // oversized last
		queue_random(60);
		drain_all();

		// Small buffer, short blocks: overflow paths.
		write_register(REG_BLOCK_SIZE, 12'd3);
		write_register(REG_SEPARATION_TIME, 12'd255);
		write_register(REG_MAX_MESSAGE_LENGTH, 12'd100);
		queue_frame(4'd8, {PCI_FIRST, 12'd101, 48'(random_word())});        // just too long
		queue_frame(4'd8, {PCI_FIRST, 12'd100, 48'(random_word())});        // just fits
		queue_frame(4'd8, {PCI_CONSECUTIVE, 4'd1, 56'(random_word())});
		queue_frame(4'd8, {PCI_FIRST, 12'hfff, 48'(random_word())});        // overflow cuts message
		queue_frame(4'd8, {PCI_CONSECUTIVE, 4'd2, 56'(random_word())});
		queue_random(80);
		// Halt the sender midway and let the results run dry.
		while (pending_frames.size() > 40)
			@(posedge clk);
		hold_sender <= 1'b1;
		wait_results();
		hold_sender <= 1'b0;
		drain_all();

		// Nothing fits: every valid first frame overflows, so no reception starts to use block size 1.
		write_register(REG_BLOCK_SIZE, 12'd1);
		write_register(REG_SEPARATION_TIME, 12'd0);
		write_register(REG_MAX_MESSAGE_LENGTH, 12'd0);
		queue_random(40);
		drain_all();

		// Largest block: one long message crosses a full block and many sequence wraps.
		write_register(REG_BLOCK_SIZE, 12'd255);
		write_register(REG_SEPARATION_TIME, 12'($urandom_range(0, 255)));
		write_register(REG_MAX_MESSAGE_LENGTH, 12'hfff);
		queue_message(1800, 1'b0);
		queue_random(20);
		drain_all();

		// Random middle settings.
		write_register(REG_BLOCK_SIZE, 12'($urandom_range(2, 16)));
		write_register(REG_SEPARATION_TIME, 12'($urandom_range(0, 255)));
		write_register(REG_MAX_MESSAGE_LENGTH, 12'($urandom_range(64, 600)));
		queue_random(60);
		drain_all();

		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
